### rtl/core/bai_pkg.sv
// bai_pkg: shared types, codes and constants for the bounded array list
// used by bai_ctrl, bai_dpath, bai_checker and bounded_array_insert_remove
// no dependencies
package bai_pkg;

    // default store depth and field widths
    localparam int DEPTH_DEF  = 16;
    localparam int CAP_W      = 5;
    localparam int OP_W       = 2;
    localparam int WORD_W     = 32;
    localparam int POS_W      = 4;
    localparam int COUNT_W    = 5;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd2;

    // register index (paddr word select bit)
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
    localparam logic [WORD_W-1:0] MOST_NEG  = 32'h8000_0000;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RDATA,
        S_SH_RD,
        S_SH_WR,
        S_INS_WR,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic app_wr;
        logic rem_rd;
        logic rem_done;
        logic refuse;
        logic ins_start;
        logic sh_rd;
        logic sh_wr;
        logic ins_wr;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            app_ok;
        logic            rem_ok;
        logic            ins_ok;
        logic            shift_last;
        logic            out_free;
    } t_stat;

endpackage

### rtl/core/bai_ctrl.sv
// bai_ctrl: sequencer for append, remove and the insert shift sweep
// depends on bai_pkg (t_state, t_cmd, t_stat, opcodes)
module bai_ctrl
    import bai_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_APPEND: n_state = S_DONE;
                    OP_REMOVE: n_state = i_stat.rem_ok ? S_RDATA : S_DONE;
                    OP_INSERT: n_state = i_stat.ins_ok ? S_SH_RD : S_DONE;
                    default:   n_state = S_DONE;
                endcase
            end
            S_RDATA:  n_state = S_DONE;
            S_SH_RD:  n_state = S_SH_WR;
            S_SH_WR: begin
                n_state = i_stat.shift_last ? S_INS_WR : S_SH_RD;
            end
            S_INS_WR: n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.latch_in = i_in_valid;
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_APPEND: begin
                        o_cmd.app_wr = i_stat.app_ok;
                        o_cmd.refuse = !i_stat.app_ok;
                    end
                    OP_REMOVE: begin
                        o_cmd.rem_rd = i_stat.rem_ok;
                        o_cmd.refuse = !i_stat.rem_ok;
                    end
                    OP_INSERT: begin
                        o_cmd.ins_start = i_stat.ins_ok;
                        o_cmd.refuse    = !i_stat.ins_ok;
                    end
                    default:   o_cmd.refuse = 1'b1;
                endcase
            end
            S_RDATA:  o_cmd.rem_done = 1'b1;
            S_SH_RD:  o_cmd.sh_rd    = 1'b1;
            S_SH_WR:  o_cmd.sh_wr    = 1'b1;
            S_INS_WR: o_cmd.ins_wr   = 1'b1;
            S_DONE:   o_cmd.out_load = i_stat.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

### rtl/core/bai_dpath.sv
// bai_dpath: entry memory, count, shift pointer and result registers
// depends on bai_pkg (t_cmd, t_stat, widths, opcodes)
module bai_dpath
    import bai_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic [CAP_W-1:0]         i_capacity,
    input  logic [OP_W-1:0]          i_opcode,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic [POS_W-1:0]         i_position,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_accepted,
    output logic signed [WORD_W-1:0] o_removed_value,
    output logic [COUNT_W-1:0]       o_count,
    output logic                     o_full_res,
    output logic                     o_empty_res
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int PW     = (ADDR_W > POS_W) ? ADDR_W : POS_W;

    // latched input word
    logic [OP_W-1:0]   r_op;
    logic [WORD_W-1:0] r_value;
    logic [POS_W-1:0]  r_pos;

    logic [CNT_W-1:0]  r_occ;
    logic [ADDR_W-1:0] r_ptr;
    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    logic              r_pend_acc;
    logic [WORD_W-1:0] r_pend_rem;

    logic               r_out_valid;
    logic               r_out_acc;
    logic [WORD_W-1:0]  r_out_rem;
    logic [COUNT_W-1:0] r_out_cnt;
    logic               r_out_full;
    logic               r_out_empty;

    logic [CNT_W-1:0]  occ_m1;
    logic [ADDR_W-1:0] occ_a;
    logic [ADDR_W-1:0] ptr_m1;
    logic [PW-1:0]     pos_w;
    logic [ADDR_W-1:0] pos_a;
    logic [CMP_W-1:0]  occ_c;
    logic [CMP_W-1:0]  cap_c;
    logic [CMP_W-1:0]  pos_c;
    logic              full;

    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [WORD_W-1:0] mem_wdata;

    // address and compare helpers
    assign occ_m1 = r_occ - CNT_W'(1);
    assign occ_a  = r_occ[ADDR_W-1:0];
    assign ptr_m1 = r_ptr - ADDR_W'(1);
    assign pos_w  = PW'(r_pos);
    assign pos_a  = pos_w[ADDR_W-1:0];
    assign occ_c  = CMP_W'(r_occ);
    assign cap_c  = CMP_W'(i_capacity);
    assign pos_c  = CMP_W'(r_pos);

    // full when count reaches capacity or the store depth
    assign full = (occ_c >= cap_c) || (r_occ == CNT_W'(DEPTH));

    // status to the controller
    always_comb begin
        o_stat.op         = r_op;
        o_stat.app_ok     = !full;
        o_stat.rem_ok     = (r_occ != '0);
        o_stat.ins_ok     = !full && (pos_c < occ_c);
        o_stat.shift_last = (ptr_m1 == pos_a);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // memory port select
    always_comb begin
        mem_we    = i_cmd.app_wr || i_cmd.sh_wr || i_cmd.ins_wr;
        mem_re    = i_cmd.rem_rd || i_cmd.sh_rd;
        mem_waddr = i_cmd.app_wr ? occ_a : (i_cmd.sh_wr ? r_ptr : pos_a);
        mem_wdata = i_cmd.sh_wr ? r_rdata : r_value;
        mem_raddr = i_cmd.rem_rd ? occ_m1[ADDR_W-1:0] : ptr_m1;
    end

    // entry memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // input word capture and shift pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op    <= i_opcode;
            r_value <= i_value;
            r_pos   <= i_position;
        end
        if (i_cmd.ins_start) begin
            r_ptr <= occ_a;
        end else if (i_cmd.sh_wr) begin
            r_ptr <= ptr_m1;
        end
    end

    // occupied count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.app_wr || i_cmd.ins_wr) begin
            r_occ <= r_occ + CNT_W'(1);
        end else if (i_cmd.rem_rd) begin
            r_occ <= occ_m1;
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.app_wr || i_cmd.ins_wr) begin
            r_pend_acc <= 1'b1;
            r_pend_rem <= '0;
        end else if (i_cmd.rem_done) begin
            r_pend_acc <= 1'b1;
            r_pend_rem <= r_rdata;
        end else if (i_cmd.refuse) begin
            r_pend_acc <= 1'b0;
            r_pend_rem <= (r_op == OP_REMOVE) ? MOST_NEG : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_acc   <= r_pend_acc;
            r_out_rem   <= r_pend_rem;
            r_out_cnt   <= COUNT_W'(r_occ);
            r_out_full  <= full;
            r_out_empty <= (r_occ == '0);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_out_acc;
    assign o_removed_value = r_out_rem;
    assign o_count         = r_out_cnt;
    assign o_full_res      = r_out_full;
    assign o_empty_res     = r_out_empty;

endmodule

### rtl/core/bounded_array_insert_remove.sv
// bounded_array_insert_remove: top level, apb capacity register and core wiring
// depends on bai_pkg, bai_ctrl, bai_dpath
//
// usage
//   input channel: i_in_valid / o_in_ready with i_opcode, i_value, i_position
//   (append, remove last, insert at position). output channel: o_out_valid /
//   i_out_ready with o_accepted, o_removed_value, o_count, o_full_res,
//   o_empty_res. every input word yields exactly one result word.
//   capacity sits at byte address 0 of the apb port; write it only while idle.
// sequencing
//   one word is in work at a time: a new word is taken only after the result
//   of the last one is loaded into the output register. a remove reads the
//   last entry through the registered read port of the entry memory. an insert
//   runs a shift sweep from the top of the list down to the position: each
//   moved entry is read, then written back one place higher, and the new value
//   is then written at the position.
// reset
//   synchronous active-low reset empties the list and sets capacity to 16.
//   memory contents are not cleared; only entries below the count are read.
// stall
//   the result sits in an output register; the next word is accepted while it
//   waits, and its own result holds in the core until that register frees up.
module bounded_array_insert_remove
    import bai_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [OP_W-1:0]          i_opcode,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic [POS_W-1:0]         i_position,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_accepted,
    output logic signed [WORD_W-1:0] o_removed_value,
    output logic [COUNT_W-1:0]       o_count,
    output logic                     o_full_res,
    output logic                     o_empty_res,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    logic [CAP_W-1:0] r_cap;
    logic             cfg_wr;
    t_cmd             cmd;
    t_stat            stat;

    // apb capacity register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(r_cap) : '0;

    // sequencer
    bai_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    bai_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_capacity      (r_cap),
        .i_opcode        (i_opcode),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_accepted      (o_accepted),
        .o_removed_value (o_removed_value),
        .o_count         (o_count),
        .o_full_res      (o_full_res),
        .o_empty_res     (o_empty_res)
    );

endmodule

### rtl/core/bai_checker.sv
// bai_checker: port-level checks for bounded_array_insert_remove, bound below
// depends on bai_pkg and the top level's port list
module bai_checker
    import bai_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic                     o_accepted,
    input logic signed [WORD_W-1:0] o_removed_value,
    input logic [COUNT_W-1:0]       o_count,
    input logic                     o_empty_res
);

    // result valid, removed value, count and accepted flag hold while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_removed_value)
            && $stable(o_count) && $stable(o_accepted))
        else $error("result word changed while stalled");

    // empty flag agrees with count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_empty_res == (o_count == '0)))
        else $error("empty flag disagrees with count");

    // refused ops return zero or the most negative word
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_accepted |->
            (o_removed_value == '0) || (o_removed_value == MOST_NEG))
        else $error("refused op returned a data word");

    // one word in work: not ready right after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken while one is in work");

    // no result straight out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind bounded_array_insert_remove bai_checker u_bai_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_accepted      (o_accepted),
    .o_removed_value (o_removed_value),
    .o_count         (o_count),
    .o_empty_res     (o_empty_res)
);
